// ===== hw/rtl/cis_cftable_entry_parser_macros.svh =====
// Assertion macros shared by the entry parser RTL.
`ifndef CIS_CFTABLE_ENTRY_PARSER_MACROS_SVH
`define CIS_CFTABLE_ENTRY_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CFTE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CFTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cfte_pkg.sv =====
// Types, phase codes, record kinds and decode tables of the entry parser.
package cfte_pkg;

    localparam int MAX_REC = 5;

    // Parse phases.
    localparam logic [4:0] PH_HEAD      = 5'd0;
    localparam logic [4:0] PH_IFACE     = 5'd1;
    localparam logic [4:0] PH_FEAT      = 5'd2;
    localparam logic [4:0] PH_PWR_MASK  = 5'd3;
    localparam logic [4:0] PH_PWR_VAL   = 5'd4;
    localparam logic [4:0] PH_PWR_EXT   = 5'd5;
    localparam logic [4:0] PH_TIM_SCALE = 5'd6;
    localparam logic [4:0] PH_TIM_WAIT  = 5'd7;
    localparam logic [4:0] PH_TIM_READY = 5'd8;
    localparam logic [4:0] PH_TIM_RSV   = 5'd9;
    localparam logic [4:0] PH_IO_FLAGS  = 5'd10;
    localparam logic [4:0] PH_IO_RANGE  = 5'd11;
    localparam logic [4:0] PH_IO_BASE   = 5'd12;
    localparam logic [4:0] PH_IO_LEN    = 5'd13;
    localparam logic [4:0] PH_IRQ1      = 5'd14;
    localparam logic [4:0] PH_IRQ2      = 5'd15;
    localparam logic [4:0] PH_MEM_S     = 5'd16;
    localparam logic [4:0] PH_MEM_DESC  = 5'd17;
    localparam logic [4:0] PH_MEM_LEN   = 5'd18;
    localparam logic [4:0] PH_MEM_CA    = 5'd19;
    localparam logic [4:0] PH_MEM_HA    = 5'd20;
    localparam logic [4:0] PH_MISC      = 5'd21;
    localparam logic [4:0] PH_MISC_EXT  = 5'd22;
    localparam logic [4:0] PH_SPARE     = 5'd23;
    localparam logic [4:0] PH_SKIP      = 5'd24;

    // Sections in tuple order.
    localparam logic [2:0] SEC_TIM  = 3'd0;
    localparam logic [2:0] SEC_IO   = 3'd1;
    localparam logic [2:0] SEC_IRQ  = 3'd2;
    localparam logic [2:0] SEC_MEM  = 3'd3;
    localparam logic [2:0] SEC_MISC = 3'd4;

    // Record kinds.
    localparam logic [4:0] K_INDEX    = 5'd0;
    localparam logic [4:0] K_IFACE    = 5'd1;
    localparam logic [4:0] K_POWER    = 5'd2;
    localparam logic [4:0] K_PWRFLAGS = 5'd3;
    localparam logic [4:0] K_WAIT     = 5'd4;
    localparam logic [4:0] K_READY    = 5'd5;
    localparam logic [4:0] K_RSV      = 5'd6;
    localparam logic [4:0] K_IOFLAGS  = 5'd7;
    localparam logic [4:0] K_IOBASE   = 5'd8;
    localparam logic [4:0] K_IOLEN    = 5'd9;
    localparam logic [4:0] K_IRQ1     = 5'd10;
    localparam logic [4:0] K_IRQ2     = 5'd11;
    localparam logic [4:0] K_MEM_LEN  = 5'd12;
    localparam logic [4:0] K_MEM_CA   = 5'd13;
    localparam logic [4:0] K_MEM_HA   = 5'd14;
    localparam logic [4:0] K_FLAGS    = 5'd15;
    localparam logic [4:0] K_SUBT     = 5'd16;
    localparam logic [4:0] K_ERROR    = 5'd17;

    // Power extension byte codes.
    localparam logic [7:0] EXT_HIGHZ_OK  = 8'h7d;
    localparam logic [7:0] EXT_ZERO      = 8'h7e;
    localparam logic [7:0] EXT_HIGHZ_REQ = 8'h7f;

    localparam logic [6:0] MANT_TAB [16] = '{
        7'd10, 7'd12, 7'd13, 7'd15, 7'd20, 7'd25, 7'd30, 7'd35,
        7'd40, 7'd45, 7'd50, 7'd55, 7'd60, 7'd70, 7'd80, 7'd90
    };
    // Mantissa divided by ten, for the unit exponent.
    localparam logic [3:0] MANT_DIV10 [16] = '{
        4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3,
        4'd4, 4'd4, 4'd5, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9
    };
    localparam logic [23:0] EXP_TAB [8] = '{
        24'd1, 24'd10, 24'd100, 24'd1000, 24'd10000, 24'd100000,
        24'd1000000, 24'd10000000
    };
    // Exponent divided by ten (unit exponent handled separately).
    localparam logic [19:0] EXP_DIV10 [8] = '{
        20'd0, 20'd1, 20'd10, 20'd100, 20'd1000, 20'd10000,
        20'd100000, 20'd1000000
    };

    typedef struct packed {
        logic [4:0]  kind;
        logic [4:0]  sub;
        logic [31:0] value;
        logic [23:0] scale;
        logic        done;
    } t_rec;

    typedef struct packed {
        logic [4:0]  phase;
        logic [7:0]  feature;
        logic [1:0]  rail;
        logic [6:0]  pmask;
        logic [2:0]  pnum;
        logic [27:0] paccum;
        logic [2:0]  pexp;
        logic [1:0]  rflags;
        logic [7:0]  tcode;
        logic [4:0]  wtotal;
        logic [4:0]  wnum;
        logic [2:0]  bbytes;
        logic [2:0]  lbytes;
        logic [2:0]  bpos;
        logic [31:0] waccum;
        logic        host;
        logic [7:0]  flags;
        logic [7:0]  spare;
    } t_state;

endpackage

// ===== hw/rtl/cfte_step.sv =====
// Combinational decode of one tuple byte: next parser state and its records.
module cfte_step import cfte_pkg::*; (
    input  t_state             i_state,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    output t_state             o_state,
    output t_rec [MAX_REC-1:0] o_recs,
    output logic [2:0]         o_cnt
);

    typedef struct packed {
        t_state             s;
        t_rec [MAX_REC-1:0] recs;
        logic [2:0]         cnt;
    } t_work;

    function automatic t_work emit(t_work w, logic [4:0] k, logic [4:0] sb,
                                   logic [31:0] v, logic [23:0] sc, logic d);
        t_rec r;
        r.kind  = k;
        r.sub   = sb;
        r.value = v;
        r.scale = sc;
        r.done  = d;
        if (w.cnt < 3'(MAX_REC)) begin
            w.recs[w.cnt] = r;
            w.cnt = w.cnt + 3'd1;
        end
        return w;
    endfunction

    function automatic logic [31:0] pwr_val(logic [3:0] m, logic [2:0] e);
        logic [31:0] v;
        if (e == 3'd0) begin
            v = 32'(MANT_DIV10[m]);
        end else begin
            v = 32'(MANT_TAB[m]) * 32'(EXP_DIV10[e]);
        end
        return v;
    endfunction

    function automatic logic [31:0] speed_val(logic [7:0] b);
        logic [31:0] v;
        if (b[6:3] == 4'd0) begin
            v = '0;
        end else begin
            v = pwr_val(b[6:3] - 4'd1, b[2:0]);
        end
        return v;
    endfunction

    function automatic logic [31:0] merge_byte(logic [31:0] acc, logic [1:0] pos,
                                               logic [7:0] b);
        logic [31:0] r;
        r = acc;
        case (pos)
            2'd0:    r[7:0]   = acc[7:0]   | b;
            2'd1:    r[15:8]  = acc[15:8]  | b;
            2'd2:    r[23:16] = acc[23:16] | b;
            default: r[31:24] = acc[31:24] | b;
        endcase
        return r;
    endfunction

    function automatic t_work sec_begin(t_work w, logic [2:0] sec);
        logic [7:0] f;
        f = w.s.feature;
        if (sec <= SEC_TIM && f[2]) begin
            w.s.phase = PH_TIM_SCALE;
        end else if (sec <= SEC_IO && f[3]) begin
            w.s.phase = PH_IO_FLAGS;
        end else if (sec <= SEC_IRQ && f[4]) begin
            w.s.phase = PH_IRQ1;
        end else if (sec <= SEC_MEM && f[6:5] != 2'b00) begin
            if (f[6:5] == 2'b11) begin
                w.s.phase = PH_MEM_DESC;
            end else begin
                w.s.phase  = PH_MEM_S;
                w.s.bpos   = '0;
                w.s.waccum = '0;
                w.s.lbytes = (f[6:5] == 2'b01) ? 3'd2 : 3'd4;
            end
        end else if (sec <= SEC_MISC && f[7]) begin
            w.s.phase = PH_MISC;
        end else begin
            w.s.phase = PH_SPARE;
            w.s.spare = '0;
        end
        return w;
    endfunction

    function automatic t_work pwr_next(t_work w, logic [3:0] start);
        logic found;
        found = 1'b0;
        for (int i = 0; i < 7; i++) begin
            if (!found && 4'(i) >= start && w.s.pmask[i]) begin
                w.s.pnum  = 3'(i);
                w.s.phase = PH_PWR_VAL;
                found     = 1'b1;
            end
        end
        if (!found) begin
            w = emit(w, K_PWRFLAGS, {w.s.rail, 3'b000},
                     {22'd0, w.s.rflags, 1'b0, w.s.pmask}, '0, 1'b0);
            w.s.rail = w.s.rail + 2'd1;
            if (w.s.rail < w.s.feature[1:0] && w.s.rail != 2'd0) begin
                w.s.phase = PH_PWR_MASK;
            end else begin
                w = sec_begin(w, SEC_TIM);
            end
        end
        return w;
    endfunction

    function automatic t_work pwr_done(t_work w);
        w = emit(w, K_POWER, {w.s.rail, w.s.pnum}, {4'd0, w.s.paccum}, '0, 1'b0);
        w = pwr_next(w, {1'b0, w.s.pnum} + 4'd1);
        return w;
    endfunction

    function automatic t_work tim_next(t_work w, logic [1:0] from);
        if (from == 2'd0 && w.s.tcode[1:0] != 2'b11) begin
            w.s.phase = PH_TIM_WAIT;
        end else if (from <= 2'd1 && w.s.tcode[4:2] != 3'b111) begin
            w.s.phase = PH_TIM_READY;
        end else if (from <= 2'd2 && w.s.tcode[7:5] != 3'b111) begin
            w.s.phase = PH_TIM_RSV;
        end else begin
            w = sec_begin(w, SEC_IO);
        end
        return w;
    endfunction

    function automatic t_work io_len_start(t_work w);
        w.s.waccum = '0;
        w.s.bpos   = '0;
        if (w.s.lbytes != 3'd0) begin
            w.s.phase = PH_IO_LEN;
        end else begin
            w = emit(w, K_IOLEN, w.s.wnum, 32'd1, '0, 1'b0);
            w.s.wnum = w.s.wnum + 5'd1;
            if (w.s.wnum >= w.s.wtotal) begin
                w = sec_begin(w, SEC_IRQ);
            end else begin
                // A window with no length bytes always has base bytes.
                w.s.phase = PH_IO_BASE;
            end
        end
        return w;
    endfunction

    function automatic t_work io_window_start(t_work w);
        w.s.waccum = '0;
        w.s.bpos   = '0;
        if (w.s.bbytes != 3'd0) begin
            w.s.phase = PH_IO_BASE;
        end else begin
            w = emit(w, K_IOBASE, w.s.wnum, '0, '0, 1'b0);
            w = io_len_start(w);
        end
        return w;
    endfunction

    // Walks memory window pieces until one needs bytes; empty pieces emit zero.
    function automatic t_work mem_start(t_work w, logic [1:0] first);
        logic [1:0] piece;
        logic [2:0] size;
        logic       stop;
        piece = first;
        stop  = 1'b0;
        for (int it = 0; it < 8; it++) begin
            if (!stop) begin
                if (piece == 2'd3) begin
                    w.s.wnum = w.s.wnum + 5'd1;
                    if (w.s.wnum >= w.s.wtotal) begin
                        w    = sec_begin(w, SEC_MISC);
                        stop = 1'b1;
                    end else begin
                        piece = 2'd0;
                    end
                end else if (piece == 2'd2 && !w.s.host) begin
                    piece = 2'd3;
                end else begin
                    size = (piece == 2'd0) ? w.s.lbytes : w.s.bbytes;
                    if (size == 3'd0) begin
                        w = emit(w, K_MEM_LEN + 5'(piece), w.s.wnum, '0, '0, 1'b0);
                        piece = piece + 2'd1;
                    end else begin
                        w.s.phase  = PH_MEM_LEN + 5'(piece);
                        w.s.bpos   = '0;
                        w.s.waccum = '0;
                        stop       = 1'b1;
                    end
                end
            end
        end
        return w;
    endfunction

    t_work       w;
    logic        bad;
    logic [6:0]  ext;
    logic [23:0] ext_add;
    logic [28:0] ext_sum;
    logic [1:0]  piece;
    logic [2:0]  size;
    logic [1:0]  fld;

    always_comb begin
        w       = '0;
        w.s     = i_state;
        bad     = 1'b0;
        ext     = i_byte[6:0];
        ext_add = '0;
        ext_sum = '0;
        piece   = '0;
        size    = '0;
        fld     = '0;
        unique case (i_state.phase)
            PH_HEAD: begin
                w.s.flags = {7'd0, i_byte[6]};
                w = emit(w, K_INDEX, '0, {26'd0, i_byte[5:0]}, '0, 1'b0);
                if (i_byte[7]) begin
                    w.s.phase = PH_IFACE;
                end else begin
                    w = emit(w, K_IFACE, '0, '0, '0, 1'b0);
                    w.s.phase = PH_FEAT;
                end
            end
            PH_IFACE: begin
                w.s.flags[4:1] = w.s.flags[4:1] | i_byte[7:4];
                w = emit(w, K_IFACE, '0, {28'd0, i_byte[3:0]}, '0, 1'b0);
                w.s.phase = PH_FEAT;
            end
            PH_FEAT: begin
                w.s.feature = i_byte;
                if (i_byte[1:0] != 2'b00) begin
                    w.s.rail  = '0;
                    w.s.phase = PH_PWR_MASK;
                end else begin
                    w = sec_begin(w, SEC_TIM);
                end
            end
            PH_PWR_MASK: begin
                w.s.pmask  = i_byte[6:0];
                w.s.rflags = '0;
                w = pwr_next(w, 4'd0);
            end
            PH_PWR_VAL: begin
                w.s.paccum = 28'(pwr_val(i_byte[6:3], i_byte[2:0]));
                w.s.pexp   = i_byte[2:0];
                if (i_byte[7]) begin
                    w.s.phase = PH_PWR_EXT;
                end else begin
                    w = pwr_done(w);
                end
            end
            PH_PWR_EXT: begin
                if (ext < 7'd100) begin
                    // Fraction in hundredths of the parameter's scale.
                    if (i_state.pexp >= 3'd2) begin
                        ext_add = 24'(ext) * 24'(EXP_TAB[i_state.pexp - 3'd2]);
                    end else if (i_state.pexp == 3'd1) begin
                        ext_add = 24'((18'(ext) * 18'd205) >> 11);
                    end
                    ext_sum = {1'b0, i_state.paccum} + 29'(ext_add);
                    w.s.paccum = ext_sum[28] ? 28'hfffffff : ext_sum[27:0];
                end else if (i_byte == EXT_HIGHZ_OK) begin
                    w.s.rflags[0] = 1'b1;
                end else if (i_byte == EXT_ZERO) begin
                    w.s.paccum = '0;
                end else if (i_byte == EXT_HIGHZ_REQ) begin
                    w.s.rflags[1] = 1'b1;
                end else begin
                    bad = 1'b1;
                end
                if (!bad && !i_byte[7]) begin
                    w = pwr_done(w);
                end
            end
            PH_TIM_SCALE: begin
                w.s.tcode = i_byte;
                w = tim_next(w, 2'd0);
            end
            PH_TIM_WAIT: begin
                w = emit(w, K_WAIT, '0, speed_val(i_byte),
                         EXP_TAB[{1'b0, i_state.tcode[1:0]}], 1'b0);
                w = tim_next(w, 2'd1);
            end
            PH_TIM_READY: begin
                w = emit(w, K_READY, '0, speed_val(i_byte),
                         EXP_TAB[i_state.tcode[4:2]], 1'b0);
                w = tim_next(w, 2'd2);
            end
            PH_TIM_RSV: begin
                w = emit(w, K_RSV, '0, speed_val(i_byte),
                         EXP_TAB[i_state.tcode[7:5]], 1'b0);
                w = tim_next(w, 2'd3);
            end
            PH_IO_FLAGS: begin
                w.s.waccum = {24'd0, i_byte};
                if (i_byte[7]) begin
                    w.s.phase = PH_IO_RANGE;
                end else begin
                    w = emit(w, K_IOFLAGS, '0, {24'd0, i_byte}, '0, 1'b0);
                    w = emit(w, K_IOBASE, '0, '0, '0, 1'b0);
                    w = emit(w, K_IOLEN, '0, 32'd1 << i_byte[4:0], '0, 1'b0);
                    w = sec_begin(w, SEC_IRQ);
                end
            end
            PH_IO_RANGE: begin
                w = emit(w, K_IOFLAGS, '0, {16'd0, i_byte, i_state.waccum[7:0]}, '0, 1'b0);
                w.s.wtotal = {1'b0, i_byte[3:0]} + 5'd1;
                fld = i_byte[5:4];
                w.s.bbytes = (fld == 2'b11) ? 3'd4 : {1'b0, fld};
                fld = i_byte[7:6];
                w.s.lbytes = (fld == 2'b11) ? 3'd4 : {1'b0, fld};
                w.s.wnum   = '0;
                if (w.s.bbytes == 3'd0 && w.s.lbytes == 3'd0) begin
                    w = sec_begin(w, SEC_IRQ);
                end else begin
                    w = io_window_start(w);
                end
            end
            PH_IO_BASE: begin
                w.s.waccum = merge_byte(i_state.waccum, i_state.bpos[1:0], i_byte);
                w.s.bpos   = i_state.bpos + 3'd1;
                if (w.s.bpos >= i_state.bbytes) begin
                    w = emit(w, K_IOBASE, i_state.wnum, w.s.waccum, '0, 1'b0);
                    w = io_len_start(w);
                end
            end
            PH_IO_LEN: begin
                w.s.waccum = merge_byte(i_state.waccum, i_state.bpos[1:0], i_byte);
                w.s.bpos   = i_state.bpos + 3'd1;
                if (w.s.bpos >= i_state.lbytes) begin
                    w = emit(w, K_IOLEN, i_state.wnum, w.s.waccum + 32'd1, '0, 1'b0);
                    w.s.wnum = i_state.wnum + 5'd1;
                    if (w.s.wnum >= i_state.wtotal) begin
                        w = sec_begin(w, SEC_IRQ);
                    end else begin
                        w = io_window_start(w);
                    end
                end
            end
            PH_IRQ1: begin
                w = emit(w, K_IRQ1, '0, {24'd0, i_byte}, '0, 1'b0);
                if (i_byte[4]) begin
                    w.s.phase = PH_IRQ2;
                    w.s.bpos  = '0;
                end else begin
                    w = sec_begin(w, SEC_MEM);
                end
            end
            PH_IRQ2: begin
                if (i_state.bpos == 3'd0) begin
                    w.s.waccum = {24'd0, i_byte};
                    w.s.bpos   = 3'd1;
                end else begin
                    w = emit(w, K_IRQ2, '0, {16'd0, i_byte, i_state.waccum[7:0]}, '0, 1'b0);
                    w = sec_begin(w, SEC_MEM);
                end
            end
            PH_MEM_S: begin
                w.s.waccum = merge_byte(i_state.waccum, i_state.bpos[1:0], i_byte);
                w.s.bpos   = i_state.bpos + 3'd1;
                if (w.s.bpos >= i_state.lbytes) begin
                    w = emit(w, K_MEM_LEN, '0, {8'd0, w.s.waccum[15:0], 8'd0}, '0, 1'b0);
                    w = emit(w, K_MEM_CA, '0, {8'd0, w.s.waccum[31:16], 8'd0}, '0, 1'b0);
                    w = sec_begin(w, SEC_MISC);
                end
            end
            PH_MEM_DESC: begin
                w.s.wtotal = {2'd0, i_byte[2:0]} + 5'd1;
                w.s.lbytes = {1'b0, i_byte[4:3]};
                w.s.bbytes = {1'b0, i_byte[6:5]};
                w.s.host   = i_byte[7];
                w.s.wnum   = '0;
                if (i_last) begin
                    bad = 1'b1;
                end else if (i_byte[6:3] == 4'd0) begin
                    w = sec_begin(w, SEC_MISC);
                end else begin
                    w = mem_start(w, 2'd0);
                end
            end
            PH_MEM_LEN, PH_MEM_CA, PH_MEM_HA: begin
                piece = 2'(i_state.phase - PH_MEM_LEN);
                size  = (piece == 2'd0) ? i_state.lbytes : i_state.bbytes;
                w.s.waccum = merge_byte(i_state.waccum, i_state.bpos[1:0], i_byte);
                w.s.bpos   = i_state.bpos + 3'd1;
                if (w.s.bpos >= size) begin
                    w = emit(w, K_MEM_LEN + 5'(piece), i_state.wnum,
                             {w.s.waccum[23:0], 8'd0}, '0, 1'b0);
                    w = mem_start(w, piece + 2'd1);
                end
            end
            PH_MISC: begin
                w.s.flags[7:5] = i_state.flags[7:5] | i_byte[5:3];
                if (i_byte[7]) begin
                    w.s.phase = PH_MISC_EXT;
                end else begin
                    w.s.phase = PH_SPARE;
                    w.s.spare = '0;
                end
            end
            PH_MISC_EXT: begin
                if (!i_byte[7]) begin
                    w.s.phase = PH_SPARE;
                    w.s.spare = '0;
                end
            end
            PH_SPARE: begin
                w.s.spare = i_state.spare + 8'd1;
            end
            default: begin
            end
        endcase

        if (bad) begin
            w = emit(w, K_ERROR, '0, '0, '0, 1'b1);
            w.s.phase = i_last ? PH_HEAD : PH_SKIP;
        end else if (i_last) begin
            if (w.s.phase == PH_SPARE) begin
                w = emit(w, K_FLAGS, '0, {24'd0, w.s.flags}, '0, 1'b0);
                w = emit(w, K_SUBT, '0, {24'd0, w.s.spare}, '0, 1'b1);
            end else if (w.s.phase != PH_SKIP) begin
                w = emit(w, K_ERROR, '0, '0, '0, 1'b1);
            end
            w.s.phase = PH_HEAD;
        end
    end

    assign o_state = w.s;
    assign o_recs  = w.recs;
    assign o_cnt   = w.cnt;

endmodule

// ===== hw/rtl/cis_cftable_entry_parser.sv =====
// Top level of the configuration-table-entry tuple parser.
//
//  channel | dir | tdata                      | tlast      | tuser
//  s       | in  | data_byte [7:0]            | last_byte  | -
//  m       | out | sub_index, value, scale    | entry_done | record_kind
//
// Each tuple byte is held in the input register, where the combinational decode
// logic turns it into zero to five records. The records sit in a five-entry
// record buffer and leave one per cycle on the master side while it is ready.
// The next byte is decoded in the cycle the buffer hands out its final record,
// so the sustained rate is one byte per cycle for bytes with at most one record
// while the master side accepts.
// Reset (synchronous, active low) returns the parser to the index byte and
// empties both registers. A stall on the master side holds the buffer and,
// once the input register is full, backs up to the slave side.
`include "cis_cftable_entry_parser_macros.svh"

module cis_cftable_entry_parser import cfte_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tlast,   // last_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [4:0] sub_index, [36:5] field_value,
                                     // [60:37] time_scale, [63:61] zero
    output logic        o_m_tlast,   // entry_done
    output logic [4:0]  o_m_tuser    // [4:0] record_kind
);

    // Input register.
    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_last;

    // Parser state.
    t_state             r_st;
    t_state             w_st;
    t_rec [MAX_REC-1:0] w_recs;
    logic [2:0]         w_cnt;

    // Record buffer: r_len records loaded, r_ptr points at the next to send.
    t_rec [MAX_REC-1:0] r_recs;
    logic [2:0]         r_len;
    logic [2:0]         r_ptr;
    t_rec               w_head;

    logic               w_take;
    logic               w_buf_free;
    logic               w_process;

    cfte_step u_step (
        .i_state (r_st),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_state (w_st),
        .o_recs  (w_recs),
        .o_cnt   (w_cnt)
    );

    assign w_head     = r_recs[r_ptr];
    assign o_m_tvalid = (r_ptr < r_len);
    assign w_take     = o_m_tvalid && i_m_tready;
    // The buffer can be reloaded once its last record is leaving.
    assign w_buf_free = !o_m_tvalid || (w_take && (r_ptr + 3'd1 == r_len));
    assign w_process  = r_in_valid && w_buf_free;
    assign o_s_tready = !r_in_valid || w_process;

    assign o_m_tdata = {3'd0, w_head.scale, w_head.value, w_head.sub};
    assign o_m_tlast = w_head.done;
    assign o_m_tuser = w_head.kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_st       <= '0;
            r_len      <= '0;
            r_ptr      <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_process) begin
                r_st  <= w_st;
                r_len <= w_cnt;
                r_ptr <= '0;
            end else if (w_take) begin
                r_ptr <= r_ptr + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
        if (w_process) begin
            r_recs <= w_recs;
        end
    end

    `CFTE_ASSERT_NOW(a_ptr_in_range, 1'b1, r_ptr <= r_len, "record pointer ran past the buffer")
    `CFTE_ASSERT_NOW(a_done_kind, o_m_tvalid && o_m_tlast, o_m_tuser == K_SUBT || o_m_tuser == K_ERROR, "entry_done on a record that does not close the tuple")
    `CFTE_ASSERT_NOW(a_last_has_records, w_process && r_in_last && r_st.phase != PH_SKIP, w_cnt != 3'd0, "final byte produced no closing record")
    `CFTE_ASSERT_NEXT(a_last_rewinds, w_process && r_in_last, r_st.phase == PH_HEAD, "parser did not return to the index byte after the final byte")

endmodule
